[rtl/fpa_pkg.sv]
`default_nettype none
package fpa_pkg;

   localparam int unsigned WordBits = 32;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } op_type;

   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [WordBits-1:0] res;
      logic                cmp;
      logic                dz;
   } ctl_type;

endpackage
`default_nettype wire

[rtl/fixed_point_alu.sv]
`default_nettype none
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits (Q24.8 by default).
// One operation is taken per cycle while the output is not stalled, and every
// operation takes the same path, through the divider, which retires one
// quotient bit per stage over a 32 + FRAC_BITS bit dividend. The whole pipe
// advances whenever the output register is empty or being taken, so order is
// kept for all opcodes. The opcode travels in req_tuser, the two operands in
// req_tdata; the result returns in rsp_tdata with the compare and divide-by-zero
// flags in rsp_tuser.
module fixed_point_alu
   import fpa_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // operand_a[31:0], operand_b[63:32]
   input  wire logic [3:0]  req_tuser,   // op[3:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // result_raw[31:0]
   output logic [1:0]       rsp_tuser    // compare_true[0], divide_by_zero[1]
);

   localparam int unsigned DW = WordBits + FRAC_BITS;

   logic en;

   // input stage
   logic                       s1_valid_ff;
   op_type                     s1_op_ff;
   logic signed [WordBits-1:0] s1_a_ff, s1_b_ff;

   // operand stage
   ctl_type                     s2_ff, s2_in;
   logic signed [2*WordBits-1:0] s2_prod_ff;
   logic [DW-1:0]               s2_dq_ff;
   logic [WordBits-1:0]         s2_dvs_ff;
   logic                        s2_neg_ff;

   // divider stages, index 0 is the entry stage
   ctl_type             ctl_ff [0:DW];
   logic [WordBits-1:0] rem_ff [0:DW];
   logic [DW-1:0]       dq_ff  [0:DW];
   logic [WordBits-1:0] dvs_ff [0:DW];
   logic                neg_ff [0:DW];

   ctl_type             out_ff;

   assign en         = !out_ff.valid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
      if (en) begin
         s1_op_ff <= op_type'(req_tuser);
         s1_a_ff  <= req_tdata[31:0];
         s1_b_ff  <= req_tdata[63:32];
      end
   end

   logic [WordBits-1:0] mag_a, mag_b;

   always_comb begin
      mag_a = s1_a_ff[WordBits-1] ? WordBits'(-s1_a_ff) : s1_a_ff;
      mag_b = s1_b_ff[WordBits-1] ? WordBits'(-s1_b_ff) : s1_b_ff;
      s2_in       = '0;
      s2_in.valid = s1_valid_ff;
      s2_in.op    = s1_op_ff;
      unique case (s1_op_ff)
         OP_ADD:      s2_in.res = s1_a_ff + s1_b_ff;
         OP_SUB:      s2_in.res = s1_a_ff - s1_b_ff;
         OP_MUL:      s2_in.res = '0;
         OP_DIV:      s2_in.dz  = (s1_b_ff == '0);
         OP_GT:       s2_in.cmp = (s1_a_ff > s1_b_ff);
         OP_LT:       s2_in.cmp = (s1_a_ff < s1_b_ff);
         OP_GE:       s2_in.cmp = (s1_a_ff >= s1_b_ff);
         OP_LE:       s2_in.cmp = (s1_a_ff <= s1_b_ff);
         OP_EQ:       s2_in.cmp = (s1_a_ff == s1_b_ff);
         OP_NE:       s2_in.cmp = (s1_a_ff != s1_b_ff);
         OP_MIN:      s2_in.res = (s1_a_ff < s1_b_ff) ? s1_a_ff : s1_b_ff;
         OP_MAX:      s2_in.res = (s1_a_ff > s1_b_ff) ? s1_a_ff : s1_b_ff;
         OP_INC:      s2_in.res = s1_a_ff + WordBits'(1);
         OP_DEC:      s2_in.res = s1_a_ff - WordBits'(1);
         OP_FROM_INT: s2_in.res = s1_a_ff << FRAC_BITS;
         OP_TO_INT:   s2_in.res = s1_a_ff >>> FRAC_BITS;
         default:     s2_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else if (en) begin
         s2_ff <= s2_in;
      end
      if (en) begin
         s2_prod_ff <= s1_a_ff * s1_b_ff;
         s2_dq_ff   <= {mag_a, FRAC_BITS'(0)};
         s2_dvs_ff  <= mag_b;
         s2_neg_ff  <= s1_a_ff[WordBits-1] ^ s1_b_ff[WordBits-1];
      end
   end

   // product shift, then divider entry
   logic [2*WordBits-1:0] prod_shift;
   ctl_type               ctl0_in;

   always_comb begin
      prod_shift = s2_prod_ff >>> FRAC_BITS;
      ctl0_in    = s2_ff;
      if (s2_ff.op == OP_MUL) begin
         ctl0_in.res = prod_shift[WordBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl0_in;
      end
      if (en) begin
         rem_ff[0] <= '0;
         dq_ff[0]  <= s2_dq_ff;
         dvs_ff[0] <= s2_dvs_ff;
         neg_ff[0] <= s2_neg_ff;
      end
   end

   for (genvar k = 0; k < DW; k++) begin : g_div
      logic [WordBits:0]   trial;
      logic                fits;
      logic [WordBits:0]   diff;

      always_comb begin
         trial = {rem_ff[k], dq_ff[k][DW-1]};
         fits  = (trial >= {1'b0, dvs_ff[k]});
         diff  = trial - {1'b0, dvs_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1] <= '0;
         end else if (en) begin
            ctl_ff[k+1] <= ctl_ff[k];
         end
         if (en) begin
            rem_ff[k+1] <= fits ? diff[WordBits-1:0] : trial[WordBits-1:0];
            dq_ff[k+1]  <= {dq_ff[k][DW-2:0], fits};
            dvs_ff[k+1] <= dvs_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   ctl_type             out_in;
   logic [WordBits-1:0] quot;

   always_comb begin
      quot   = dq_ff[DW][WordBits-1:0];
      out_in = ctl_ff[DW];
      if (ctl_ff[DW].op == OP_DIV) begin
         out_in.res = ctl_ff[DW].dz ? '0 : (neg_ff[DW] ? WordBits'(-quot) : quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = out_ff.res;
   assign rsp_tuser  = {out_ff.dz, out_ff.cmp};

endmodule
`default_nettype wire

[rtl/fixed_point_alu_checker.sv]
`default_nettype none
module fixed_point_alu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled with free output");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("compare and divide flags both set");

   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 32'd0)
      else $error("nonzero result on zero divisor");

endmodule

bind fixed_point_alu fixed_point_alu_checker u_checker (.*);
`default_nettype wire

[tb/tb_fixed_point_alu.sv]
module tb_fixed_point_alu;
   import fpa_pkg::*;

   localparam int unsigned FracBits = 8;
   localparam int unsigned Latency = FracBits + 36;
   localparam longint unsigned CycleLimit = 600000;

   typedef struct packed {
      logic [31:0] result_raw;
      logic        compare_true;
      logic        divide_by_zero;
   } alu_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // operand_a[31:0], operand_b[63:32]
   logic [3:0]  req_tuser = '0;   // op[3:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // result_raw[31:0]
   logic [1:0]  rsp_tuser;        // compare_true[0], divide_by_zero[1]

   alu_result_type  pending_results[$];
   int unsigned     mismatch_count = 0;
   longint unsigned cycle_count = 0;
   bit              stall_rsp = 1'b1;

   fixed_point_alu #(.FRAC_BITS(FracBits)) dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic alu_result_type compute_alu(op_type op, logic signed [31:0] a,
                                                  logic signed [31:0] b);
      alu_result_type r;
      logic signed [63:0] wide;
      r = '0;
      case (op)
         OP_ADD: r.result_raw = a + b;
         OP_SUB: r.result_raw = a - b;
         OP_MUL: begin
            wide = 64'(a) * 64'(b);
            r.result_raw = 32'(wide >>> FracBits);
         end
         OP_DIV: begin
            if (b == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               // truncate toward zero
               wide = (64'(a) <<< FracBits) / 64'(b);
               r.result_raw = 32'(wide);
            end
         end
         OP_GT: r.compare_true = a > b;
         OP_LT: r.compare_true = a < b;
         OP_GE: r.compare_true = a >= b;
         OP_LE: r.compare_true = a <= b;
         OP_EQ: r.compare_true = a == b;
         OP_NE: r.compare_true = a != b;
         OP_MIN: r.result_raw = (a < b) ? a : b;
         OP_MAX: r.result_raw = (a > b) ? a : b;
         OP_INC: r.result_raw = a + 1;
         OP_DEC: r.result_raw = a - 1;
         OP_FROM_INT: r.result_raw = a << FracBits;
         default: r.result_raw = a >>> FracBits;
      endcase
      return r;
   endfunction

   task automatic send_op(op_type op, logic [31:0] a, logic [31:0] b);
      int unsigned gap;
      gap = gap_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {b, a};
      pending_results.push_back(compute_alu(op, a, b));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         3: return 32'($signed($urandom_range(0, 4096)) - 2048);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_op(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
      send_op(OP_SUB, 32'h8000_0000, 32'h0000_0001);
      send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
      send_op(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
      send_op(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
      send_op(OP_DIV, 32'h0000_1234, 32'h0000_0000);
      send_op(OP_DIV, 32'h8000_0000, 32'hffff_ff00);
      send_op(OP_DIV, 32'hffff_fd00, 32'h0000_0200);
      send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
      send_op(OP_GT, 32'h8000_0000, 32'h7fff_ffff);
      send_op(OP_LT, 32'h8000_0000, 32'h7fff_ffff);
      send_op(OP_GE, 32'h0000_0005, 32'h0000_0005);
      send_op(OP_LE, 32'hffff_ffff, 32'h0000_0000);
      send_op(OP_EQ, 32'hdead_beef, 32'hdead_beef);
      send_op(OP_NE, 32'hdead_beef, 32'hdead_beef);
      send_op(OP_MIN, 32'h0000_0007, 32'h0000_0007);
      send_op(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
      send_op(OP_INC, 32'h7fff_ffff, 32'hffff_ffff);
      send_op(OP_DEC, 32'h8000_0000, 32'hffff_ffff);
      send_op(OP_FROM_INT, 32'h00ff_ffff, 32'h0);
      send_op(OP_FROM_INT, 32'h8000_0001, 32'h0);
      send_op(OP_TO_INT, 32'hffff_ff01, 32'h0);
      send_op(OP_TO_INT, 32'h7fff_ffff, 32'h0);
      end_burst();
   endtask

   task automatic test_drain_pause();
      // hold the sender until every expected result is back
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_random(int unsigned count);
      logic [31:0] a;
      logic [31:0] b;
      op_type      op;
      repeat (count) begin
         op = op_type'($urandom_range(0, 15));
         a = random_operand();
         b = (op == OP_DIV && $urandom_range(0, 9) == 0) ? 32'h0 : random_operand();
         if ($urandom_range(0, 9) == 0) b = a;
         send_op(op, a, b);
      end
      end_burst();
   endtask

   task automatic test_full_rate(int unsigned count);
      stall_rsp = 1'b0;
      repeat (count) begin
         req_tvalid <= 1'b1;
         req_tuser <= 4'($urandom_range(0, 15));
         req_tdata <= {$urandom, $urandom};
         // hold the transfer until it is taken
         do @(posedge clock); while (!req_tready);
         pending_results.push_back(compute_alu(op_type'(req_tuser),
                                               req_tdata[31:0], req_tdata[63:32]));
      end
      end_burst();
      stall_rsp = 1'b1;
   endtask

   // compare every result transfer against the oldest expectation
   always @(posedge clock) begin
      alu_result_type want;
      cycle_count <= cycle_count + 1;
      if (!reset)
         rsp_tready <= stall_rsp ? (gap_length() == 0) : 1'b1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h/%b", $time, rsp_tdata, rsp_tuser);
            mismatch_count <= mismatch_count + 1;
         end else begin
            want = pending_results.pop_front();
            if (want.result_raw !== rsp_tdata || want.compare_true !== rsp_tuser[0]
                || want.divide_by_zero !== rsp_tuser[1]) begin
               $display("%0t: expected %h cmp %b dz %b, actual %h cmp %b dz %b", $time,
                        want.result_raw, want.compare_true, want.divide_by_zero,
                        rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
               mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drain_pause();
      test_random(800);
      test_drain_pause();
      test_full_rate(300);
      test_random(600);
      test_drain_pause();
      repeat (Latency * 2) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
